>>> rtl/atclp_pkg.sv
// Package: codes, command texts and helper functions of the AT command-line parser.
`default_nettype none

package atclp_pkg;

   // Number of characters of a line that are kept; later ones are dropped.
   localparam int LINE_CHARS = 31;
   localparam int POS_W      = $clog2(LINE_CHARS + 1);

   // Largest register number that a peek or poke may address.
   localparam logic [15:0] REG_MAX = 16'd255;

   // Parse phases of a line.
   localparam int PHASE_W = 3;
   localparam logic [PHASE_W-1:0] PH_EMPTY = 3'd0;
   localparam logic [PHASE_W-1:0] PH_GOT_A = 3'd1;
   localparam logic [PHASE_W-1:0] PH_AT    = 3'd2;
   localparam logic [PHASE_W-1:0] PH_MATCH = 3'd3;
   localparam logic [PHASE_W-1:0] PH_NUM1  = 3'd4;
   localparam logic [PHASE_W-1:0] PH_NUM2  = 3'd5;
   localparam logic [PHASE_W-1:0] PH_EXACT = 3'd6;

   // Command kinds.
   typedef logic [2:0] kind_type;
   localparam kind_type K_NONE    = 3'd0;
   localparam kind_type K_VERSION = 3'd1;
   localparam kind_type K_MODEL   = 3'd2;
   localparam kind_type K_TURBO   = 3'd3;
   localparam kind_type K_PEEK    = 3'd4;
   localparam kind_type K_POKE    = 3'd5;
   localparam kind_type K_AMP     = 3'd6;

   // Response codes.
   localparam logic [2:0] RESP_OK      = 3'd0;
   localparam logic [2:0] RESP_ERROR   = 3'd1;
   localparam logic [2:0] RESP_VERSION = 3'd2;
   localparam logic [2:0] RESP_MODEL   = 3'd3;
   localparam logic [2:0] RESP_REG     = 3'd4;

   // Action codes.
   localparam logic [2:0] ACT_NONE  = 3'd0;
   localparam logic [2:0] ACT_TURBO = 3'd1;
   localparam logic [2:0] ACT_READ  = 3'd2;
   localparam logic [2:0] ACT_WRITE = 3'd3;
   localparam logic [2:0] ACT_AMP   = 3'd4;

   // Command texts, left aligned in eight characters and padded with zero bytes.
   localparam logic [63:0] TXT_VERSION = "+VERSION";
   localparam logic [63:0] TXT_MODEL   = {"+MODEL", 16'h0000};
   localparam logic [63:0] TXT_TURBO   = {"+TURBO", 16'h0000};
   localparam logic [63:0] TXT_PEEK    = {"+PEEK=", 16'h0000};
   localparam logic [63:0] TXT_POKE    = {"+POKE=", 16'h0000};
   localparam logic [63:0] TXT_AMP     = {"+AMP=", 24'h000000};

   // Character of a command's text at a given index.
   function automatic logic [7:0] cmd_char(input kind_type kind, input logic [2:0] idx);
      logic [63:0] txt;
      case (kind)
         K_VERSION: txt = TXT_VERSION;
         K_MODEL:   txt = TXT_MODEL;
         K_TURBO:   txt = TXT_TURBO;
         K_PEEK:    txt = TXT_PEEK;
         K_POKE:    txt = TXT_POKE;
         K_AMP:     txt = TXT_AMP;
         default:   txt = 64'h0;
      endcase
      return txt[8*(3'd7 - idx) +: 8];
   endfunction

   // Length of a command's text.
   function automatic logic [3:0] cmd_len(input kind_type kind);
      logic [3:0] len;
      case (kind)
         K_VERSION: len = 4'd8;
         K_MODEL:   len = 4'd6;
         K_TURBO:   len = 4'd6;
         K_PEEK:    len = 4'd6;
         K_POKE:    len = 4'd6;
         K_AMP:     len = 4'd5;
         default:   len = 4'd0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

>>> rtl/at_command_line_parser_core.sv
// AT command-line parser: one character per item, one result item per non-empty line.
//
// The req channel carries one character per item (req_char_byte), with
// req_end_of_line set on the line's last item; req_char_present is low for an
// end marker without a character. Letters are folded to upper case and the
// command is recognised as it arrives. When a line ends, one result item
// leaves on the rsp channel with a response code, an action code, a register
// number, a write value and the amplifier state; an empty line gives none.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low.
// Timing: an item is registered in the input register on acceptance, then decoded, and
// its result is registered in the result register and shown on rsp; a stall keeps it waiting.
// Throughput: one item per cycle while rsp_stall holds no waiting result, set by the single
// decode step between the input register and the line state and result registers.
// Reset (synchronous, active high) empties both registers and returns the
// line state to the start of a line. While rsp_stall holds a waiting result,
// one more item may be taken into the input register, and req_stall rises
// only once that register is full as well.
`default_nettype none

module at_command_line_parser_core
   import atclp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_char_byte,
   input  wire logic        req_end_of_line,
   input  wire logic        req_char_present,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_response_code,
   output logic [2:0]       rsp_action_code,
   output logic [7:0]       rsp_register_number,
   output logic [15:0]      rsp_write_value,
   output logic             rsp_amplifier_on
);

   // Input register.
   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_char_ff;
   logic              in_eol_ff;
   logic              in_present_ff;

   // Line state.
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   kind_type           kind_ff, kind_in;
   logic [15:0]        acc_ff, acc_in;
   logic [7:0]         held_ff, held_in;
   logic               err_ff, err_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         resp_ff, resp_in;
   logic [2:0]         act_ff, act_in;
   logic [7:0]         reg_ff, reg_in;
   logic [15:0]        val_ff, val_in;
   logic               amp_ff, amp_in;

   // Decode signals.
   logic               out_free;
   logic               fire;
   logic               accept;
   logic               take;
   logic [7:0]         ch;
   logic [2:0]         idx;
   kind_type           kind_cur;
   logic [15:0]        acc_times_ten;
   logic [PHASE_W-1:0] line_phase;
   logic [POS_W-1:0]   line_pos;
   kind_type           line_kind;
   logic [15:0]        line_acc;
   logic [7:0]         line_held;
   logic               line_err;
   logic               produce;

   // Handshake: the decode step runs whenever the result register can take its output.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Character folding and the index into the command text.
   assign ch = (in_char_ff >= "a" && in_char_ff <= "z") ? in_char_ff - 8'd32 : in_char_ff;
   assign idx = 3'(pos_ff - POS_W'(2));
   assign acc_times_ten = (acc_ff << 3) + (acc_ff << 1);
   assign take = in_present_ff && !err_ff && (pos_ff < POS_W'(LINE_CHARS));

   // Effect of one character on the line state.
   always_comb begin
      line_phase = phase_ff;
      line_pos   = pos_ff;
      line_kind  = kind_ff;
      line_acc   = acc_ff;
      line_held  = held_ff;
      line_err   = err_ff;
      kind_cur   = kind_ff;
      if (take) begin
         if (in_char_ff == 8'h00) begin
            // A zero byte ends the kept text.
            line_pos = POS_W'(LINE_CHARS);
         end else begin
            line_pos = pos_ff + POS_W'(1);
            case (phase_ff)
               PH_EMPTY: begin
                  if (ch == "A") line_phase = PH_GOT_A;
                  else line_err = 1'b1;
               end
               PH_GOT_A: begin
                  if (ch == "T") line_phase = PH_AT;
                  else line_err = 1'b1;
               end
               PH_AT: begin
                  if (ch == "+") begin
                     line_phase = PH_MATCH;
                     line_kind  = K_NONE;
                  end else begin
                     line_err = 1'b1;
                  end
               end
               PH_MATCH: begin
                  // The first letter picks the command; PEEK turns into POKE on an O.
                  if (kind_ff == K_NONE) begin
                     case (ch)
                        "V":     kind_cur = K_VERSION;
                        "M":     kind_cur = K_MODEL;
                        "T":     kind_cur = K_TURBO;
                        "P":     kind_cur = K_PEEK;
                        "A":     kind_cur = K_AMP;
                        default: kind_cur = K_NONE;
                     endcase
                  end else if (kind_ff == K_PEEK && idx == 3'd2 && ch == "O") begin
                     kind_cur = K_POKE;
                  end
                  line_kind = kind_cur;
                  if (kind_cur == K_NONE || cmd_char(kind_cur, idx) != ch) begin
                     line_err = 1'b1;
                  end else if ({1'b0, idx} + 4'd1 == cmd_len(kind_cur)) begin
                     if (kind_cur == K_VERSION || kind_cur == K_MODEL ||
                         kind_cur == K_TURBO) begin
                        line_phase = PH_EXACT;
                     end else begin
                        line_phase = PH_NUM1;
                        line_acc   = 16'd0;
                     end
                  end
               end
               PH_NUM1, PH_NUM2: begin
                  // Decimal digits accumulate, spaces are skipped, a poke takes one comma.
                  if (ch >= "0" && ch <= "9") begin
                     line_acc = acc_times_ten + {12'd0, 4'(ch - "0")};
                  end else if (ch == " ") begin
                     line_acc = acc_ff;
                  end else if (ch == "," && phase_ff == PH_NUM1 && kind_ff == K_POKE) begin
                     if (acc_ff > REG_MAX) begin
                        line_err = 1'b1;
                     end else begin
                        line_held  = acc_ff[7:0];
                        line_acc   = 16'd0;
                        line_phase = PH_NUM2;
                     end
                  end else begin
                     line_err = 1'b1;
                  end
               end
               default: begin
                  line_err = 1'b1;
               end
            endcase
         end
      end
   end

   // Result of a line that ends with this item.
   always_comb begin
      produce = line_err || (line_phase != PH_EMPTY);
      resp_in = RESP_ERROR;
      act_in  = ACT_NONE;
      reg_in  = 8'd0;
      val_in  = 16'd0;
      amp_in  = 1'b0;
      if (!line_err) begin
         case (line_phase)
            PH_AT: begin
               resp_in = RESP_OK;
            end
            PH_EXACT: begin
               if (line_kind == K_VERSION) begin
                  resp_in = RESP_VERSION;
               end else if (line_kind == K_MODEL) begin
                  resp_in = RESP_MODEL;
               end else if (line_kind == K_TURBO) begin
                  resp_in = RESP_OK;
                  act_in  = ACT_TURBO;
               end
            end
            PH_NUM1: begin
               if (line_kind == K_PEEK && line_acc <= REG_MAX) begin
                  resp_in = RESP_REG;
                  act_in  = ACT_READ;
                  reg_in  = line_acc[7:0];
               end else if (line_kind == K_AMP) begin
                  resp_in = RESP_OK;
                  act_in  = ACT_AMP;
                  amp_in  = (line_acc != 16'd0);
               end
            end
            PH_NUM2: begin
               if (line_kind == K_POKE) begin
                  resp_in = RESP_OK;
                  act_in  = ACT_WRITE;
                  reg_in  = line_held;
                  val_in  = line_acc;
               end
            end
            default: begin
               resp_in = RESP_ERROR;
            end
         endcase
      end
   end

   // Next line state: back to the start of a line after its end.
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      kind_in  = kind_ff;
      acc_in   = acc_ff;
      held_in  = held_ff;
      err_in   = err_ff;
      if (fire) begin
         if (in_eol_ff) begin
            phase_in = PH_EMPTY;
            pos_in   = '0;
            kind_in  = K_NONE;
            acc_in   = 16'd0;
            held_in  = 8'd0;
            err_in   = 1'b0;
         end else begin
            phase_in = line_phase;
            pos_in   = line_pos;
            kind_in  = line_kind;
            acc_in   = line_acc;
            held_in  = line_held;
            err_in   = line_err;
         end
      end
   end

   // Result valid: loaded whenever the result register is free.
   assign rsp_valid_in = out_free ? (fire && in_eol_ff && produce) : rsp_valid_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_EMPTY;
         pos_ff       <= '0;
         kind_ff      <= K_NONE;
         acc_ff       <= 16'd0;
         held_ff      <= 8'd0;
         err_ff       <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         kind_ff      <= kind_in;
         acc_ff       <= acc_in;
         held_ff      <= held_in;
         err_ff       <= err_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff    <= req_char_byte;
         in_eol_ff     <= req_end_of_line;
         in_present_ff <= req_char_present;
      end
      if (out_free && fire && in_eol_ff && produce) begin
         resp_ff <= resp_in;
         act_ff  <= act_in;
         reg_ff  <= reg_in;
         val_ff  <= val_in;
         amp_ff  <= amp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_response_code   = resp_ff;
   assign rsp_action_code     = act_ff;
   assign rsp_register_number = reg_ff;
   assign rsp_write_value     = val_ff;
   assign rsp_amplifier_on    = amp_ff;

`ifndef NO_ASSERTIONS
   // A held item that cannot advance stays in the input register.
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> in_valid_ff)
      else $error("held item lost from the input register");

   // The line state is back at the start after every line end.
   a_line_clear: assert property (@(posedge clock) disable iff (reset)
      (fire && in_eol_ff) |=> (phase_ff == PH_EMPTY && pos_ff == '0 && !err_ff))
      else $error("line state not cleared after a line end");

   // A new result only follows the decode of a line end.
   a_result_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fire && in_eol_ff))
      else $error("result item without a line end");
`endif

endmodule

`default_nettype wire

>>> bench/at_command_line_parser_checker.sv
// Checker for the AT command-line parser: predicts each reply from the accepted characters.
module at_command_line_parser_checker
   import atclp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_char_byte,
   input  logic        req_end_of_line,
   input  logic        req_char_present,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_response_code,
   input  logic [2:0]  rsp_action_code,
   input  logic [7:0]  rsp_register_number,
   input  logic [15:0] rsp_write_value,
   input  logic        rsp_amplifier_on,
   output int          mismatch_count,
   output int          replies_awaited
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0]  code;
      logic [2:0]  action;
      logic [7:0]  reg_num;
      logic [15:0] value;
      logic        amp;
   } reply_type;

   // Replies that the lines closed so far call for, oldest first.
   reply_type awaited[$];

   // Line state of the parser as predicted here.
   logic [PHASE_W-1:0] phase;
   int                 pos;
   kind_type           kind;
   logic [15:0]        acc;
   logic [15:0]        held_reg;
   bit                 line_err;

   initial begin
      mismatch_count  = 0;
      replies_awaited = 0;
   end

   task automatic clear_line();
      phase    = PH_EMPTY;
      pos      = 0;
      kind     = K_NONE;
      acc      = '0;
      held_reg = '0;
      line_err = 1'b0;
   endtask

   // Advance the line state by one kept character.
   task automatic take_char(input logic [7:0] raw);
      logic [7:0] c;
      int         idx;
      string      word;
      if (!line_err && pos < LINE_CHARS) begin
         if (raw == 8'h00) begin
            // A zero byte ends the kept text of the line.
            pos = LINE_CHARS;
         end else begin
            c = (raw >= "a" && raw <= "z") ? raw - 8'd32 : raw;
            case (phase)
               PH_EMPTY: begin
                  if (c == "A") phase = PH_GOT_A;
                  else line_err = 1'b1;
               end
               PH_GOT_A: begin
                  if (c == "T") phase = PH_AT;
                  else line_err = 1'b1;
               end
               PH_AT: begin
                  if (c == "+") begin
                     phase = PH_MATCH;
                     kind  = K_NONE;
                  end else begin
                     line_err = 1'b1;
                  end
               end
               PH_MATCH: begin
                  idx = pos - 2;
                  // The first letter picks the command; PEEK turns into POKE on its O.
                  if (kind == K_NONE) begin
                     case (c)
                        "V":     kind = K_VERSION;
                        "M":     kind = K_MODEL;
                        "T":     kind = K_TURBO;
                        "P":     kind = K_PEEK;
                        "A":     kind = K_AMP;
                        default: line_err = 1'b1;
                     endcase
                  end else if (kind == K_PEEK && idx == 2 && c == "O") begin
                     kind = K_POKE;
                  end
                  case (kind)
                     K_VERSION: word = "+VERSION";
                     K_MODEL:   word = "+MODEL";
                     K_TURBO:   word = "+TURBO";
                     K_PEEK:    word = "+PEEK=";
                     K_POKE:    word = "+POKE=";
                     K_AMP:     word = "+AMP=";
                     default:   word = "";
                  endcase
                  if (!line_err) begin
                     if (idx >= word.len() || word[idx] != c) begin
                        line_err = 1'b1;
                     end else if (idx + 1 == word.len()) begin
                        if (kind == K_VERSION || kind == K_MODEL || kind == K_TURBO) begin
                           phase = PH_EXACT;
                        end else begin
                           phase = PH_NUM1;
                           acc   = '0;
                        end
                     end
                  end
               end
               PH_NUM1, PH_NUM2: begin
                  if (c >= "0" && c <= "9") begin
                     acc = acc * 16'd10 + 16'(c - "0");
                  end else if (c == " ") begin
                     // Spaces inside numbers are skipped.
                  end else if (c == "," && phase == PH_NUM1 && kind == K_POKE) begin
                     if (acc > REG_MAX) begin
                        line_err = 1'b1;
                     end else begin
                        held_reg = acc;
                        acc      = '0;
                        phase    = PH_NUM2;
                     end
                  end else begin
                     line_err = 1'b1;
                  end
               end
               default: line_err = 1'b1;
            endcase
            pos++;
         end
      end
   endtask

   // Work out the reply of a finished line, if it has one, and start a new line.
   task automatic close_line();
      reply_type r;
      r      = '0;
      r.code = RESP_ERROR;
      if (line_err || phase != PH_EMPTY) begin
         if (!line_err) begin
            case (phase)
               PH_AT: r.code = RESP_OK;
               PH_EXACT: begin
                  if (kind == K_VERSION) begin
                     r.code = RESP_VERSION;
                  end else if (kind == K_MODEL) begin
                     r.code = RESP_MODEL;
                  end else if (kind == K_TURBO) begin
                     r.code   = RESP_OK;
                     r.action = ACT_TURBO;
                  end
               end
               PH_NUM1: begin
                  if (kind == K_PEEK && acc <= REG_MAX) begin
                     r.code    = RESP_REG;
                     r.action  = ACT_READ;
                     r.reg_num = acc[7:0];
                  end else if (kind == K_AMP) begin
                     r.code   = RESP_OK;
                     r.action = ACT_AMP;
                     r.amp    = (acc != 16'd0);
                  end
               end
               PH_NUM2: begin
                  if (kind == K_POKE) begin
                     r.code    = RESP_OK;
                     r.action  = ACT_WRITE;
                     r.reg_num = held_reg[7:0];
                     r.value   = acc;
                  end
               end
               default: begin
               end
            endcase
         end
         awaited.push_back(r);
      end
      clear_line();
   endtask

   // Follow both channels and compare every reply with the oldest prediction.
   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         clear_line();
         awaited.delete();
      end else begin
         if (req_valid && !req_stall) begin
            if (req_char_present) take_char(req_char_byte);
            if (req_end_of_line) close_line();
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: unexpected reply code=%0d action=%0d reg=%0d value=%0d amp=%0d",
                           $time, rsp_response_code, rsp_action_code, rsp_register_number,
                           rsp_write_value, rsp_amplifier_on);
               mismatch_count++;
            end else begin
               want = awaited.pop_front();
               if (rsp_response_code !== want.code || rsp_action_code !== want.action ||
                   rsp_register_number !== want.reg_num || rsp_write_value !== want.value ||
                   rsp_amplifier_on !== want.amp) begin
                  if (mismatch_count < 10) begin
                     $write("%0t: reply mismatch, expected code=%0d action=%0d reg=%0d ",
                            $time, want.code, want.action, want.reg_num);
                     $write("value=%0d amp=%0d, got code=%0d action=%0d reg=%0d ",
                            want.value, want.amp, rsp_response_code, rsp_action_code,
                            rsp_register_number);
                     $display("value=%0d amp=%0d", rsp_write_value, rsp_amplifier_on);
                  end
                  mismatch_count++;
               end
            end
         end
      end
      replies_awaited = awaited.size();
   end

endmodule

>>> bench/tb_at_command_line_parser_core.sv
// Testbench top: drives command lines into the AT parser and gives the verdict.
module tb_at_command_line_parser_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_MAX = 96;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_char_byte;
   logic        req_end_of_line;
   logic        req_char_present;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_response_code;
   logic [2:0]  rsp_action_code;
   logic [7:0]  rsp_register_number;
   logic [15:0] rsp_write_value;
   logic        rsp_amplifier_on;

   int mismatch_count;
   int replies_awaited;

   // Line under construction and run bookkeeping.
   logic [7:0] line_chars [0:LINE_MAX-1];
   int         line_len;
   int         items_sent = 0;
   int         lines_sent = 0;
   int         item_target;
   int         first_random_line;
   int         next_pause;
   int         calm_left = 0;
   int         stall_left = 0;
   wire        calm = (calm_left != 0);

   at_command_line_parser_core u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_char_byte       (req_char_byte),
      .req_end_of_line     (req_end_of_line),
      .req_char_present    (req_char_present),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_response_code   (rsp_response_code),
      .rsp_action_code     (rsp_action_code),
      .rsp_register_number (rsp_register_number),
      .rsp_write_value     (rsp_write_value),
      .rsp_amplifier_on    (rsp_amplifier_on)
   );

   at_command_line_parser_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_char_byte       (req_char_byte),
      .req_end_of_line     (req_end_of_line),
      .req_char_present    (req_char_present),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_response_code   (rsp_response_code),
      .rsp_action_code     (rsp_action_code),
      .rsp_register_number (rsp_register_number),
      .rsp_write_value     (rsp_write_value),
      .rsp_amplifier_on    (rsp_amplifier_on),
      .mismatch_count      (mismatch_count),
      .replies_awaited     (replies_awaited)
   );

   // 50 MHz clock.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Now and then both sides run for a while without any idling.
   always @(posedge clock) begin
      if (calm_left != 0) calm_left <= calm_left - 1;
      else if ($urandom_range(0, 199) == 0) calm_left <= $urandom_range(30, 150);
   end

   // Length of an idle stretch: mostly none or short, a few long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // The reply side stalls in bursts.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else begin
         stall_left = pick_gap();
         rsp_stall  = (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   // Offer one item after a random gap and hold it until it is taken.
   task automatic send_char(input logic [7:0] c, input bit eol, input bit present);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_char_byte    = c;
      req_end_of_line  = eol;
      req_char_present = present;
      req_valid        = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (present || eol) items_sent++;
   endtask

   task automatic add_char(input logic [7:0] c);
      if (line_len < LINE_MAX) begin
         line_chars[line_len] = c;
         line_len++;
      end
   endtask

   // Append text, with letters put in lower case at random when asked.
   task automatic add_text(input string s, input bit mix_case);
      logic [7:0] ch;
      for (int i = 0; i < s.len(); i++) begin
         ch = s[i];
         if (mix_case && ch >= "A" && ch <= "Z" && $urandom_range(0, 1) == 1) ch = ch + 8'd32;
         add_char(ch);
      end
   endtask

   // Append a decimal number with stray spaces; sometimes empty, sometimes beyond 16 bits.
   task automatic add_number();
      int    r;
      int    v;
      string digits;
      r = $urandom_range(0, 99);
      repeat ((r < 5) ? $urandom_range(15, 25) : $urandom_range(0, 2)) add_char(" ");
      r = $urandom_range(0, 99);
      if (r >= 10) begin
         if (r < 60) v = $urandom_range(0, 255);
         else if (r < 75) v = $urandom_range(256, 999);
         else v = $urandom_range(0, 999999);
         digits = $sformatf("%0d", v);
         for (int i = 0; i < digits.len(); i++) begin
            add_char(digits[i]);
            if ($urandom_range(0, 19) == 0) add_char(" ");
         end
      end
   endtask

   // Build a random line: mostly well-formed commands, some damaged, some plain noise.
   task automatic build_random_line();
      int    r;
      int    at;
      string junk;
      junk     = ", 0123456789XA=+";
      line_len = 0;
      r        = $urandom_range(0, 99);
      if (r < 10) begin
         repeat ($urandom_range(0, 40)) add_char(8'($urandom_range(0, 255)));
      end else begin
         case ($urandom_range(0, 6))
            0: add_text("AT", 1'b1);
            1: add_text("AT+VERSION", 1'b1);
            2: add_text("AT+MODEL", 1'b1);
            3: add_text("AT+TURBO", 1'b1);
            4: begin
               add_text("AT+PEEK=", 1'b1);
               add_number();
            end
            5: begin
               add_text("AT+POKE=", 1'b1);
               add_number();
               add_char(",");
               add_number();
            end
            default: begin
               add_text("AT+AMP=", 1'b1);
               add_number();
            end
         endcase
         // Damage a share of the lines: a wrong or zero byte, a cut, or trailing junk.
         if (r >= 85 && line_len > 0) begin
            at = $urandom_range(0, line_len - 1);
            case ($urandom_range(0, 3))
               0: line_chars[at] = 8'($urandom_range(0, 255));
               1: line_chars[at] = 8'h00;
               2: line_len = at;
               default: repeat ($urandom_range(1, 4))
                  add_char(junk[$urandom_range(0, junk.len() - 1)]);
            endcase
         end
      end
   endtask

   // Send the built line, ending on its last character or with a lone end marker.
   task automatic send_line(input bit lone_end);
      for (int i = 0; i < line_len; i++) begin
         if ($urandom_range(0, 24) == 0) send_char(8'($urandom), 1'b0, 1'b0);
         send_char(line_chars[i], !lone_end && i == line_len - 1, 1'b1);
      end
      if (lone_end || line_len == 0) send_char(8'($urandom), 1'b1, 1'b0);
      lines_sent++;
   endtask

   task automatic send_text(input string s, input bit lone_end);
      line_len = 0;
      add_text(s, 1'b0);
      send_line(lone_end);
   endtask

   // Hold the sender back until every predicted reply has come.
   task automatic wait_drained();
      req_valid = 1'b0;
      while (replies_awaited != 0) @(negedge clock);
   endtask

   // Stimulus and verdict.
   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_char_byte    = 8'h00;
      req_end_of_line  = 1'b0;
      req_char_present = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed lines: every command, number edges, errors and dropped text.
      send_text("", 1'b1);
      send_text("AT", 1'b0);
      send_text("at+version", 1'b1);
      send_text("AT+MODEL", 1'b0);
      send_text("At+tUrBo", 1'b0);
      send_text("AT+PEEK=255", 1'b0);
      send_text("AT+PEEK=256", 1'b0);
      send_text("AT+PEEK=65791", 1'b0);
      send_text("AT+PEEK=", 1'b1);
      send_text("AT+POKE= 12 , 65535", 1'b0);
      send_text("AT+POKE=1,70000", 1'b0);
      send_text("AT+POKE=7", 1'b0);
      send_text("AT+POKE=300,1", 1'b0);
      send_char(8'h55, 1'b0, 1'b0);
      send_text("AT+AMP=0", 1'b0);
      send_text("AT+AMP= 5", 1'b0);
      send_text("AT+VERSIONX", 1'b0);
      send_text("AT+PEEK=1x", 1'b0);
      send_text("AT+PO", 1'b0);
      send_text("AT+POKE=1,2                     GARBAGE", 1'b0);
      send_text("BT", 1'b0);
      line_len = 0;
      add_char(8'hFF);
      send_line(1'b0);
      line_len = 0;
      add_text("AT", 1'b0);
      add_char(8'h00);
      add_text("XYZ", 1'b0);
      send_line(1'b0);
      line_len = 0;
      add_char(8'h00);
      add_text("AT", 1'b0);
      send_line(1'b1);
      wait_drained();

      // Random lines, with a full drain every few hundred characters.
      item_target       = 1000;
      next_pause        = items_sent + 300;
      first_random_line = lines_sent;
      while (items_sent < item_target || lines_sent - first_random_line < 40) begin
         build_random_line();
         send_line($urandom_range(0, 4) == 0);
         if (items_sent >= next_pause) begin
            wait_drained();
            next_pause += 300;
         end
      end

      wait_drained();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && replies_awaited == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   // Watchdog.
   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> filelist.f
rtl/atclp_pkg.sv
rtl/at_command_line_parser_core.sv
bench/at_command_line_parser_checker.sv
bench/tb_at_command_line_parser_core.sv
